// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL files of the nearest point search.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen out of reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

// ===== design/npsd_pkg.sv =====
// ----------------------------------------------------------------------------
// npsd_pkg
// Types, constants and helpers of the nearest point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package npsd_pkg;

    // fixed field widths
    localparam int COORD_W   = 24;
    localparam int REG_W     = 24;
    localparam int IDX_W     = 10;
    localparam int DIST_W    = 50;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int COORD_BITS_DEF  = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 2'd2;

    // input word
    typedef struct packed {
        logic signed [COORD_W-1:0] cand_x;
        logic signed [COORD_W-1:0] cand_y;
        logic signed [COORD_W-1:0] cand_z;
        logic                      accepted;
        logic                      last;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_dist_sq;
        logic              list_overflow;
    } t_out_word;

    // width of one classified item in the front-to-back queue:
    // select, last, overflow flags, position, three magnitudes
    function automatic int task_w(input int max_entries, input int coord_bits);
        return 3 + $clog2(max_entries) + 3 * coord_bits;
    endfunction

endpackage

`default_nettype wire

// ===== design/npsd_fifo.sv =====
// ----------------------------------------------------------------------------
// npsd_fifo
// Small register-based FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module npsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_full_and_empty, i_clk, i_rst_n, o_full && o_empty)
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_cnt > CNT_W'(DEPTH))
    `ASSERT_CLK(a_full_rise, i_clk, i_rst_n, o_full && !$past(o_full) |-> $past(w_push && !w_pop))

endmodule

`default_nettype wire

// ===== design/npsd_front.sv =====
// ----------------------------------------------------------------------------
// npsd_front
// Input side: takes candidate words, tracks list position and overflow,
// forms per-axis distance magnitudes and queues only words that matter.
// ----------------------------------------------------------------------------
`default_nettype none

module npsd_front #(
    parameter int MAX_ENTRIES = 1024,
    parameter int COORD_BITS  = 24
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_push,
    input  wire npsd_pkg::t_in_word                     i_in_word,
    input  wire logic [npsd_pkg::REG_W-1:0]             i_ref_x,
    input  wire logic [npsd_pkg::REG_W-1:0]             i_ref_y,
    input  wire logic [npsd_pkg::REG_W-1:0]             i_ref_z,
    input  wire logic                                   i_q_full,
    output logic                                        o_q_push,
    output logic [npsd_pkg::task_w(MAX_ENTRIES, COORD_BITS)-1:0] o_q_data
);

    import npsd_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int POS_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic             sel;
        logic             last;
        logic             ovf;
        logic [POS_W-1:0] pos;
        logic [CW-1:0]    mag_x;
        logic [CW-1:0]    mag_y;
        logic [CW-1:0]    mag_z;
    } t_task;

    // |a - b| with both operands cut to CW bits and sign extended
    function automatic logic [CW-1:0] mag_diff(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic signed [31:0] ea;
        logic signed [31:0] eb;
        logic signed [CW:0] d;
        ea = 32'(signed'(a));
        eb = 32'(signed'(b));
        d  = signed'({ea[CW-1], ea[CW-1:0]}) - signed'({eb[CW-1], eb[CW-1:0]});
        if (d[CW]) begin
            d = -d;
        end
        return d[CW-1:0];
    endfunction

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             w_acc;
    logic             w_in_range;
    t_task            w_task;

    assign w_acc      = i_push && !i_q_full;
    assign w_in_range = (r_count < CNT_W'(MAX_ENTRIES));

    // classify the incoming word
    always_comb begin
        w_task.sel   = i_in_word.accepted && w_in_range;
        w_task.last  = i_in_word.last;
        w_task.ovf   = r_ovf || !w_in_range;
        w_task.pos   = r_count[POS_W-1:0];
        w_task.mag_x = mag_diff(i_in_word.cand_x, i_ref_x);
        w_task.mag_y = mag_diff(i_in_word.cand_y, i_ref_y);
        w_task.mag_z = mag_diff(i_in_word.cand_z, i_ref_z);
    end

    // words that neither compete nor close the list are dropped here
    assign o_q_push = w_acc && (w_task.sel || w_task.last);
    assign o_q_data = w_task;

    // list position and overflow tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_acc) begin
            if (i_in_word.last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_in_range) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/npsd_back.sv =====
// ----------------------------------------------------------------------------
// npsd_back
// Execution side: squares the axis magnitudes, sums and saturates them,
// keeps the running minimum and emits one result per list.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module npsd_back #(
    parameter int MAX_ENTRIES = 1024,
    parameter int COORD_BITS  = 24
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [npsd_pkg::task_w(MAX_ENTRIES, COORD_BITS)-1:0] i_q_data,
    input  wire logic                                   i_q_empty,
    output logic                                        o_q_pop,
    input  wire logic                                   i_res_full,
    output logic                                        o_res_push,
    output npsd_pkg::t_out_word                         o_res
);

    import npsd_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int POS_W  = $clog2(MAX_ENTRIES);
    localparam int SQ_W   = 2 * CW;
    localparam int SUM_W  = SQ_W + 2;
    localparam int WIDE_W = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;
    localparam logic [WIDE_W-1:0] DIST_MAX_W = {{(WIDE_W - DIST_W){1'b0}}, {DIST_W{1'b1}}};

    typedef struct packed {
        logic             sel;
        logic             last;
        logic             ovf;
        logic [POS_W-1:0] pos;
        logic [CW-1:0]    mag_x;
        logic [CW-1:0]    mag_y;
        logic [CW-1:0]    mag_z;
    } t_task;

    t_task             w_q;
    logic              w_en;

    // square stage
    logic              r_s1_v;
    logic              r_s1_sel;
    logic              r_s1_last;
    logic              r_s1_ovf;
    logic [POS_W-1:0]  r_s1_pos;
    logic [SQ_W-1:0]   r_sq_x;
    logic [SQ_W-1:0]   r_sq_y;
    logic [SQ_W-1:0]   r_sq_z;

    // search state
    logic              r_have, n_have;
    logic [DIST_W-1:0] r_best_dist, n_best_dist;
    logic [POS_W-1:0]  r_best_pos, n_best_pos;

    logic [SUM_W-1:0]  w_sum;
    logic [WIDE_W-1:0] w_wide;
    logic [DIST_W-1:0] w_dist;
    logic              w_better;

    assign w_q     = i_q_data;
    assign w_en    = !i_res_full;
    assign o_q_pop = w_en;

    // square stage, stalls as a whole on a full result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sel  <= w_q.sel;
            r_s1_last <= w_q.last;
            r_s1_ovf  <= w_q.ovf;
            r_s1_pos  <= w_q.pos;
            r_sq_x    <= SQ_W'(w_q.mag_x) * SQ_W'(w_q.mag_x);
            r_sq_y    <= SQ_W'(w_q.mag_y) * SQ_W'(w_q.mag_y);
            r_sq_z    <= SQ_W'(w_q.mag_z) * SQ_W'(w_q.mag_z);
        end
    end

    // sum, saturate, compare; ties keep the earlier candidate
    always_comb begin
        w_sum    = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
        w_wide   = WIDE_W'(w_sum);
        w_dist   = (w_wide > DIST_MAX_W) ? DIST_MAX_W[DIST_W-1:0] : w_wide[DIST_W-1:0];
        w_better = r_s1_sel && (!r_have || (w_dist < r_best_dist));
    end

    // running minimum update
    always_comb begin
        n_have      = r_have;
        n_best_dist = r_best_dist;
        n_best_pos  = r_best_pos;
        if (w_better) begin
            n_have      = 1'b1;
            n_best_dist = w_dist;
            n_best_pos  = r_s1_pos;
        end
    end

    // result word; state is zero when nothing was found
    always_comb begin
        o_res.found         = n_have;
        o_res.best_index    = IDX_W'(n_best_pos);
        o_res.best_dist_sq  = n_best_dist;
        o_res.list_overflow = r_s1_ovf;
    end

    assign o_res_push = w_en && r_s1_v && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_dist <= '0;
            r_best_pos  <= '0;
        end else if (w_en && r_s1_v) begin
            if (r_s1_last) begin
                r_have      <= 1'b0;
                r_best_dist <= '0;
                r_best_pos  <= '0;
            end else begin
                r_have      <= n_have;
                r_best_dist <= n_best_dist;
                r_best_pos  <= n_best_pos;
            end
        end
    end

    `ASSERT_CLK(a_clear_after_result, i_clk, i_rst_n, o_res_push |=> !r_have)
    `ASSERT_CLK(a_empty_state_zero, i_clk, i_rst_n, !r_have |-> (r_best_dist == '0 && r_best_pos == '0))
    `ASSERT_CLK(a_stage_holds, i_clk, i_rst_n, r_s1_v && !w_en |=> r_s1_v)

endmodule

`default_nettype wire

// ===== design/nearest_point_search_3d_core.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_3d_core
// Streaming nearest point search against a configurable 3D reference point.
// ----------------------------------------------------------------------------
// One candidate word is taken every clock while the input queue has room;
// after the last word of a list is taken, its result word passes through the
// input queue, the squaring stage register and the result queue. The compare
// of the squaring stage against the running minimum writes the result queue
// and decides one candidate per cycle while the result queue has room. Only
// a full result queue holds the squaring stage; the input side keeps taking
// words until its four-entry queue fills. The reference point must be written
// while no list is in flight. No clearing pass is needed after reset.
`default_nettype none

module nearest_point_search_3d_core #(
    parameter int MAX_ENTRIES = npsd_pkg::MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = npsd_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // candidate side
    input  wire logic                             push,
    output logic                                  full,
    input  wire npsd_pkg::t_in_word               i_in_word,
    // result side
    output logic                                  empty,
    input  wire logic                             pop,
    output npsd_pkg::t_out_word                   o_res_word,
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [npsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [npsd_pkg::REG_W-1:0]       i_cfg_data
);

    import npsd_pkg::*;

    localparam int TASK_W  = task_w(MAX_ENTRIES, COORD_BITS);
    localparam int OUT_W   = $bits(t_out_word);
    localparam int Q_DEPTH = 4;
    localparam int R_DEPTH = 2;

    logic [REG_W-1:0]  r_ref_x;
    logic [REG_W-1:0]  r_ref_y;
    logic [REG_W-1:0]  r_ref_z;

    logic              w_q_push;
    logic [TASK_W-1:0] w_q_wdata;
    logic              w_q_full;
    logic              w_q_pop;
    logic [TASK_W-1:0] w_q_rdata;
    logic              w_q_empty;

    logic              w_res_push;
    t_out_word         w_res;
    logic              w_res_full;
    logic [OUT_W-1:0]  w_res_rdata;

    // reference point registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REF_X: r_ref_x <= i_cfg_data;
                REG_REF_Y: r_ref_y <= i_cfg_data;
                REG_REF_Z: r_ref_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input side
    npsd_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_word (i_in_word),
        .i_ref_x   (r_ref_x),
        .i_ref_y   (r_ref_y),
        .i_ref_z   (r_ref_z),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_data  (w_q_wdata)
    );

    assign full = w_q_full;

    // queue between the two sides
    npsd_fifo #(
        .WIDTH (TASK_W),
        .DEPTH (Q_DEPTH)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    // execution side
    npsd_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (w_q_rdata),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    // result queue
    npsd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (R_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_rdata),
        .o_empty (empty)
    );

    assign o_res_word = w_res_rdata;

endmodule

`default_nettype wire
